@@ design/harmonic_bond_force_macros.svh @@
// Assertion shorthands shared by the design files.
// Both forms sample on the rising clock edge and are quiet while reset is high.
`ifndef HARMONIC_BOND_FORCE_MACROS_SVH
`define HARMONIC_BOND_FORCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/hbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hbf_pkg;

   // Pipeline depths of the two digit-recurrence units.
   localparam int SqrtSteps = 33;
   localparam int DivSteps  = 50;

   // Saturation values of the result fields.
   localparam logic [62:0] EnergyMax = {63{1'b1}};
   localparam logic [47:0] ForceMax  = {1'b0, {47{1'b1}}};
   localparam logic [47:0] ForceMin  = {1'b1, {47{1'b0}}};
   // Magnitude 2^47 on the quotient width.
   localparam logic [49:0] ForceLimit = 50'(1) << 47;

   // One beat on the request channel.
   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic        [31:0] spring_constant;
      logic        [30:0] rest_length;
   } req_payload_type;

   // One beat on the response channel.
   typedef struct packed {
      logic        [62:0] energy;
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic               degenerate;
   } rsp_payload_type;

   // Per-bond data carried alongside the distance computation.
   typedef struct packed {
      logic [2:0][32:0] mag;     // |d| per axis, index 0 is x
      logic [2:0]       neg;     // d below zero
      logic [2:0]       pos;     // d above zero
      logic [31:0]      spring;
      logic [30:0]      rest;
   } bond_side_type;

   // Work handed to the divider: numerators, divisor and finished energy.
   typedef struct packed {
      logic [2:0][98:0] num;
      logic [48:0]      divisor;
      logic [62:0]      energy;
      logic [2:0]       force_neg;
      logic             degenerate;
   } div_work_type;

endpackage

`default_nettype wire

@@ design/hbf_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: bond geometry and parameters.
interface hbf_req_if import hbf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Response channel: energy, force on the first atom and the degenerate flag.
interface hbf_rsp_if import hbf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/hbf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Distance vector, squared components and their sum in three stages.
module hbf_front import hbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  req_payload_type in_data,
   output logic            out_valid,
   output logic [65:0]     out_sum,
   output bond_side_type   out_side
);

   logic [2:0]       valid_ff;
   logic [2:0][31:0] first_c;
   logic [2:0][31:0] second_c;
   logic [2:0][32:0] diff_c;
   bond_side_type    side1_in, side1_ff;
   logic [2:0][65:0] sq_in, sq_ff;
   bond_side_type    side2_ff;
   logic [65:0]      sum_in, sum_ff;
   bond_side_type    side3_ff;

   assign first_c  = {in_data.first_z, in_data.first_y, in_data.first_x};
   assign second_c = {in_data.second_z, in_data.second_y, in_data.second_x};

   // Stage one: exact 33-bit difference, its magnitude and sign.
   always_comb begin
      side1_in.spring = in_data.spring_constant;
      side1_in.rest   = in_data.rest_length;
      for (int c = 0; c < 3; c++) begin
         diff_c[c] = {first_c[c][31], first_c[c]} - {second_c[c][31], second_c[c]};
         side1_in.neg[c] = diff_c[c][32];
         side1_in.pos[c] = !diff_c[c][32] && (diff_c[c] != '0);
         side1_in.mag[c] = diff_c[c][32] ? (~diff_c[c] + 33'd1) : diff_c[c];
      end
   end

   // Stage two: square each magnitude.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_in[c] = side1_ff.mag[c] * side1_ff.mag[c];
      end
   end

   // Stage three: sum of squares, below 3 * 2^64.
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      if (advance) begin
         side1_ff <= side1_in;
         sq_ff    <= sq_in;
         side2_ff <= side1_ff;
         sum_ff   <= sum_in;
         side3_ff <= side2_ff;
      end
   end

   // Valid bits move with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign out_sum   = sum_ff;
   assign out_side  = side3_ff;

endmodule

`default_nettype wire

@@ design/hbf_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring square root, one result bit per stage, floor result.
module hbf_sqrt import hbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [65:0]   in_sum,
   input  bond_side_type in_side,
   output logic          out_valid,
   output logic [32:0]   out_root,
   output bond_side_type out_side
);

   typedef struct packed {
      logic [66:0]   rem;   // radicand minus root squared
      logic [32:0]   root;
      bond_side_type bond;
   } root_work_type;

   root_work_type          head;
   root_work_type          step_in [SqrtSteps];
   root_work_type          work_ff [SqrtSteps];
   logic [SqrtSteps-1:0]   valid_ff;

   always_comb begin
      head.rem  = {1'b0, in_sum};
      head.root = '0;
      head.bond = in_side;
   end

   // Stage i decides root bit SqrtSteps-1-i.
   for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
      localparam int Bit = SqrtSteps - 1 - i;
      root_work_type src;
      logic [66:0]   trial;

      if (i == 0) begin : g_head
         assign src = head;
      end else begin : g_tail
         assign src = work_ff[i-1];
      end

      // Trial subtrahend is 2*root*2^Bit + 2^(2*Bit).
      always_comb begin
         trial      = (67'(src.root) << (Bit + 1)) | (67'(1) << (2 * Bit));
         step_in[i] = src;
         if (src.rem >= trial) begin
            step_in[i].rem  = src.rem - trial;
            step_in[i].root = src.root | (33'(1) << Bit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SqrtSteps; i++) begin
            work_ff[i] <= step_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[SqrtSteps-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[SqrtSteps-1];
   assign out_root  = work_ff[SqrtSteps-1].root;
   assign out_side  = work_ff[SqrtSteps-1].bond;

endmodule

`default_nettype wire

@@ design/hbf_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Deviation from rest length, products with the spring constant and energy.
module hbf_scale import hbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [32:0]   in_root,
   input  bond_side_type in_side,
   output logic          out_valid,
   output div_work_type  out_work
);

   typedef struct packed {
      logic [32:0]   root;
      logic          e_neg;
      logic          e_pos;
      bond_side_type bond;
   } scale_side_type;

   logic [4:0]       valid_ff;
   logic [34:0]      e_wide;
   logic [32:0]      dev_in, dev_ff;
   scale_side_type   side1_in, side1_ff;
   logic [3:0][65:0] prod_in, prod_ff;
   scale_side_type   side2_ff;
   logic [3:0][64:0] part_lo_in, part_lo_ff;
   logic [3:0][64:0] part_hi_in, part_hi_ff;
   scale_side_type   side3_ff;
   logic [3:0][97:0] total_in, total_ff;
   scale_side_type   side4_ff;
   div_work_type     work_in, work_ff;

   // Stage one: signed deviation e = r - r0 and its magnitude.
   always_comb begin
      e_wide         = {2'b00, in_root} - {4'b0000, in_side.rest};
      side1_in.root  = in_root;
      side1_in.e_neg = e_wide[34];
      side1_in.e_pos = !e_wide[34] && (e_wide != '0);
      side1_in.bond  = in_side;
      dev_in         = e_wide[34] ? 33'(~e_wide + 35'd1) : e_wide[32:0];
   end

   // Stage two: |e|^2 for the energy and |e|*|d| for each axis.
   always_comb begin
      prod_in[0] = dev_ff * dev_ff;
      for (int c = 0; c < 3; c++) begin
         prod_in[c+1] = dev_ff * side1_ff.bond.mag[c];
      end
   end

   // Stage three: split each product in halves and scale by k.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         part_lo_in[j] = prod_ff[j][32:0] * side2_ff.bond.spring;
         part_hi_in[j] = prod_ff[j][65:33] * side2_ff.bond.spring;
      end
   end

   // Stage four: join the partial products.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         total_in[j] = {part_hi_ff[j], 33'd0} + 98'(part_lo_ff[j]);
      end
   end

   // Stage five: saturate the energy, set up numerators and divisor.
   always_comb begin
      if (total_ff[0][97:95] != '0) begin
         work_in.energy = EnergyMax;
      end else begin
         work_in.energy = total_ff[0][94:32];
      end
      for (int c = 0; c < 3; c++) begin
         work_in.num[c]       = {total_ff[c+1], 1'b0};
         work_in.force_neg[c] = (side4_ff.e_pos && side4_ff.bond.pos[c])
                              || (side4_ff.e_neg && side4_ff.bond.neg[c]);
      end
      work_in.divisor    = {side4_ff.root, 16'd0};
      work_in.degenerate = (side4_ff.root == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dev_ff     <= dev_in;
         side1_ff   <= side1_in;
         prod_ff    <= prod_in;
         side2_ff   <= side1_ff;
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
         side3_ff   <= side2_ff;
         total_ff   <= total_in;
         side4_ff   <= side3_ff;
         work_ff    <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_valid = valid_ff[4];
   assign out_work  = work_ff;

endmodule

`default_nettype wire

@@ design/hbf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-lane pipelined restoring divider and the force saturation stage.
module hbf_div import hbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  div_work_type    in_work,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   typedef struct packed {
      logic [2:0][48:0] rem;
      logic [2:0][49:0] lowq;   // numerator bits still to use, quotient shifted in
      logic [48:0]      divisor;
      logic [62:0]      energy;
      logic [2:0]       force_neg;
      logic             degenerate;
   } div_step_type;

   div_step_type     head;
   div_step_type     step_in [DivSteps];
   div_step_type     work_ff [DivSteps];
   logic [DivSteps:0] valid_ff;
   div_step_type     last;
   logic [2:0][47:0] force_c;
   rsp_payload_type  result_in, result_ff;

   // The quotient stays below 2^50, so the upper numerator bits start as remainder.
   always_comb begin
      head = '0;
      for (int c = 0; c < 3; c++) begin
         head.rem[c]  = in_work.num[c][98:50];
         head.lowq[c] = in_work.num[c][49:0];
      end
      head.divisor    = in_work.divisor;
      head.energy     = in_work.energy;
      head.force_neg  = in_work.force_neg;
      head.degenerate = in_work.degenerate;
   end

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      div_step_type     src;
      logic [2:0][49:0] cand;
      logic [2:0][49:0] reduced;

      if (i == 0) begin : g_head
         assign src = head;
      end else begin : g_tail
         assign src = work_ff[i-1];
      end

      // Bring down one numerator bit, subtract when the divisor fits.
      always_comb begin
         step_in[i] = src;
         for (int c = 0; c < 3; c++) begin
            cand[c]    = {src.rem[c], src.lowq[c][49]};
            reduced[c] = cand[c] - {1'b0, src.divisor};
            if (cand[c] >= {1'b0, src.divisor}) begin
               step_in[i].rem[c]  = reduced[c][48:0];
               step_in[i].lowq[c] = {src.lowq[c][48:0], 1'b1};
            end else begin
               step_in[i].rem[c]  = cand[c][48:0];
               step_in[i].lowq[c] = {src.lowq[c][48:0], 1'b0};
            end
         end
      end
   end

   // Final stage: sign, saturation and the coincident-atom case.
   always_comb begin
      last = work_ff[DivSteps-1];
      for (int c = 0; c < 3; c++) begin
         if (last.degenerate) begin
            force_c[c] = '0;
         end else if (last.force_neg[c]) begin
            if (last.lowq[c] > ForceLimit) begin
               force_c[c] = ForceMin;
            end else begin
               force_c[c] = 48'(~last.lowq[c] + 50'd1);
            end
         end else begin
            if (last.lowq[c] >= ForceLimit) begin
               force_c[c] = ForceMax;
            end else begin
               force_c[c] = last.lowq[c][47:0];
            end
         end
      end
      result_in.energy     = last.energy;
      result_in.force_x    = force_c[0];
      result_in.force_y    = force_c[1];
      result_in.force_z    = force_c[2];
      result_in.degenerate = last.degenerate;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DivSteps; i++) begin
            work_ff[i] <= step_in[i];
         end
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DivSteps-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DivSteps];
   assign out_data  = result_ff;

endmodule

`default_nettype wire

@@ design/hbf_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "harmonic_bond_force_macros.svh"

// Two-entry output buffer; the pipeline advances whenever it has room.
module hbf_out_buf import hbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rsp_payload_type in_data,
   output logic            advance,
   hbf_rsp_if.source       rsp_chan
);

   logic [1:0]      count_ff, count_in;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   rsp_payload_type entry_ff [2];
   logic            push;
   logic            pop;

   assign advance = (count_ff != 2'd2);
   assign push    = in_valid && advance;
   assign pop     = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid   = (count_ff != 2'd0);
   assign rsp_chan.payload = entry_ff[rd_ptr_ff];

   // Occupancy and pointer update.
   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Buffer storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   `HBF_ASSERT_NEXT(a_stall_holds_result, in_valid && !advance, in_valid && $stable(in_data), "stalled result left the pipeline end")
   `HBF_ASSERT_NEXT(a_pop_decrements, pop && !push, count_ff == $past(count_ff) - 2'd1, "buffer count did not drop on a taken beat")
   `HBF_ASSERT_NEXT(a_push_increments, push && !pop, count_ff == $past(count_ff) + 2'd1, "buffer count did not rise on a stored beat")
   `HBF_ASSERT_NOW(a_degenerate_zero_force, rsp_chan.valid && rsp_chan.payload.degenerate, rsp_chan.payload.force_x == '0 && rsp_chan.payload.force_y == '0 && rsp_chan.payload.force_z == '0, "degenerate bond with nonzero force")

endmodule

`default_nettype wire

@@ design/harmonic_bond_force.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Harmonic bond stretch kernel: energy k*(r-r0)^2 and force on the first atom.
// req_chan carries one bond per beat: both atom positions (signed Q16.16),
// the spring constant and the rest length. rsp_chan returns one beat per
// bond, in order: energy, the three force components and a degenerate flag
// that is set, with zero force, when the atoms coincide.
// A bond may be sent every cycle the buffer has room: one bond per clock.
// From the accepting edge to rsp_chan.valid, three stages form the
// squared distance, 33 stages take the square root one bit each, five
// stages do the products with k, and 50 divider stages plus one
// saturation stage form the force quotient one bit each.
// A two-entry output buffer follows the pipeline. While it holds two beats
// the whole pipeline holds still and req_chan.ready is low; nothing is
// dropped or repeated. req_chan.ready depends only on registered state.
// Synchronous reset empties the pipeline and the buffer; a bond may be
// sent in the first cycle after reset.
module harmonic_bond_force import hbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hbf_req_if.sink   req_chan,
   hbf_rsp_if.source rsp_chan
);

   logic            advance;
   logic            front_valid;
   logic [65:0]     front_sum;
   bond_side_type   front_side;
   logic            sqrt_valid;
   logic [32:0]     sqrt_root;
   bond_side_type   sqrt_side;
   logic            scale_valid;
   div_work_type    scale_work;
   logic            div_valid;
   rsp_payload_type div_data;

   assign req_chan.ready = advance;

   hbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid && advance),
      .in_data   (req_chan.payload),
      .out_valid (front_valid),
      .out_sum   (front_sum),
      .out_side  (front_side)
   );

   hbf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_sum    (front_sum),
      .in_side   (front_side),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   hbf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_root   (sqrt_root),
      .in_side   (sqrt_side),
      .out_valid (scale_valid),
      .out_work  (scale_work)
   );

   hbf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scale_valid),
      .in_work   (scale_work),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   hbf_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid),
      .in_data  (div_data),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/tb_harmonic_bond_force.sv @@
`timescale 1ns / 1ps

module tb_harmonic_bond_force;
   import hbf_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hbf_req_if req_chan ();
   hbf_rsp_if rsp_chan ();

   harmonic_bond_force u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   req_payload_type bond_queue[$];
   rsp_payload_type expected_forces[$];
   int mismatch_count = 0;
   int hold_cycles = 0;
   bit sender_pause = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   // Bit-exact prediction of one bond: floor sqrt, exact products, saturation.
   function automatic rsp_payload_type bond_predict(req_payload_type b);
      rsp_payload_type res;
      logic signed [33:0] dv[3];
      logic [32:0] ad[3];
      logic [67:0] sum;
      logic [33:0] root, cand;
      logic signed [34:0] dev;
      logic [33:0] adev;
      logic [99:0] t;
      logic [255:0] num, q;
      logic [63:0] divisor;
      logic neg;
      sum = '0;
      for (int c = 0; c < 3; c++) begin
         case (c)
            0: dv[c] = 34'(b.first_x) - 34'(b.second_x);
            1: dv[c] = 34'(b.first_y) - 34'(b.second_y);
            default: dv[c] = 34'(b.first_z) - 34'(b.second_z);
         endcase
         ad[c] = dv[c] < 0 ? 33'(-dv[c]) : 33'(dv[c]);
         sum += 68'(ad[c]) * 68'(ad[c]);
      end
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         cand = root | (34'(1) << i);
         if (68'(cand) * 68'(cand) <= sum) root = cand;
      end
      dev = 35'(root) - 35'(b.rest_length);
      adev = dev < 0 ? 34'(-dev) : 34'(dev);
      t = 100'(adev) * 100'(adev) * 100'(b.spring_constant);
      res.energy = (t >> 32) > 100'(EnergyMax) ? EnergyMax : 63'(t >> 32);
      res.force_x = '0;
      res.force_y = '0;
      res.force_z = '0;
      res.degenerate = (root == 0);
      if (root != 0) begin
         divisor = 64'(root) << 16;
         for (int c = 0; c < 3; c++) begin
            num = 256'(b.spring_constant) * 256'(adev) * 256'(ad[c]) * 2;
            q = num / 256'(divisor);
            neg = (dev > 0 && dv[c] > 0) || (dev < 0 && dv[c] < 0);
            if (neg) res.force_x = q > 256'(ForceLimit) ? ForceMin : 48'(-q);
            else res.force_x = q > 256'(ForceMax) ? ForceMax : 48'(q);
            if (c == 0) res.force_y = res.force_x;
            if (c == 1) res.force_z = res.force_x;
         end
         // Rotate the axes back into place after the loop.
         {res.force_x, res.force_y, res.force_z} =
            {res.force_y, res.force_z, res.force_x};
      end
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 2000)) - 32'd1000;
         3: return 32'($urandom_range(0, 20'hFFFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type rand_bond();
      req_payload_type b;
      b.first_x = rand_coord();
      b.first_y = rand_coord();
      b.first_z = rand_coord();
      if ($urandom_range(0, 2) == 0) begin
         // Nearby atoms, like a real bond.
         b.second_x = b.first_x + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
         b.second_y = b.first_y + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
         b.second_z = b.first_z + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
      end else begin
         b.second_x = rand_coord();
         b.second_y = rand_coord();
         b.second_z = rand_coord();
      end
      if ($urandom_range(0, 30) == 0) begin
         b.second_x = b.first_x;
         b.second_y = b.first_y;
         b.second_z = b.first_z;
      end
      case ($urandom_range(0, 4))
         0: b.spring_constant = '0;
         1: b.spring_constant = '1;
         2: b.spring_constant = 32'($urandom_range(0, 32'h0100_0000));
         default: b.spring_constant = $urandom;
      endcase
      b.rest_length = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h4_0000));
      return b;
   endfunction

   function automatic req_payload_type make_bond(logic [31:0] ax, logic [31:0] ay,
         logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
         logic [31:0] k, logic [30:0] r0);
      req_payload_type b;
      b = '{ax, ay, az, bx, by, bz, k, r0};
      return b;
   endfunction

   // Driver: offer queued bonds with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) expected_forces.push_back(bond_predict(req_chan.payload));
         if (send_gap > 0 || sender_pause || bond_queue.size() == 0) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.payload <= bond_queue.pop_front();
            req_chan.valid <= 1'b1;
            send_gap <= pick_gap();
         end
      end
   end

   // Monitor: random back-pressure, compare each result with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_forces.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result beat %p", rsp_chan.payload);
            end else begin
               want = expected_forces.pop_front();
               if (want !== rsp_chan.payload) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %p, got %p", want, rsp_chan.payload);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed bonds: extremes, coincident atoms, zero and full spring.
      bond_queue.push_back(make_bond(0, 0, 0, 0, 0, 0, 32'h1_0000, 31'h1_0000));
      bond_queue.push_back(make_bond(5, 5, 5, 5, 5, 5, '1, '1));
      bond_queue.push_back(make_bond(32'h1_0000, 0, 0, 0, 0, 0, 32'h1_0000, 0));
      bond_queue.push_back(make_bond(0, 32'h2_0000, 0, 0, 0, 0, 32'h1_0000, 31'h1_0000));
      bond_queue.push_back(make_bond(0, 0, 32'h8000, 0, 0, 0, 32'h1_0000, 31'h1_0000));
      bond_queue.push_back(make_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 0));
      bond_queue.push_back(make_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1));
      bond_queue.push_back(make_bond(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, '1));
      bond_queue.push_back(make_bond(1, 0, 0, 0, 0, 0, '1, '1));
      bond_queue.push_back(make_bond(0, 1, 0, 0, 0, 0, '1, 0));
      bond_queue.push_back(make_bond(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h1_0000, 31'h1_0000));
      bond_queue.push_back(make_bond(32'h3_0000, 32'h4_0000, 0, 0, 0, 0, 32'h1_0000, 31'h5_0000));
      bond_queue.push_back(make_bond(32'hFFFD_0000, 32'h4_0000, 32'h2_0000, 0, 0, 0,
         32'h8000_0000, 31'h1_0000));
      bond_queue.push_back(make_bond(0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
         32'h1_0000, 31'h7FFF_FFFF));

      // Sender pause until drained, then a long receiver hold while feeding.
      wait (bond_queue.size() == 0 && !req_chan.valid);
      sender_pause <= 1'b1;
      while (expected_forces.size() != 0) @(posedge clock);
      sender_pause <= 1'b0;
      hold_cycles <= 400;
      for (int i = 0; i < 300; i++) bond_queue.push_back(rand_bond());
      wait (bond_queue.size() == 0);
      for (int i = 0; i < 750; i++) bond_queue.push_back(rand_bond());
      wait (bond_queue.size() == 0 && !req_chan.valid);

      while (expected_forces.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_forces.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
